/* rtl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared types and constants of the HSV to RGB colour converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int NUM_STAGES = 6;

    // Reciprocal of 255 with a 24-bit shift: exact floor for numerators up to 65025
    localparam int          RECIP_255_SHIFT = 24;
    localparam logic [16:0] RECIP_255       = 17'd65794;

    // Reciprocal of 65025 with a 41-bit shift: exact floor for numerators up to 16581375
    localparam int          RECIP_65025_SHIFT = 41;
    localparam logic [25:0] RECIP_65025       = 26'd33818121;

    // Hue thresholds at which the sector advances (6 * hue crosses a multiple of 255)
    localparam logic [7:0] HUE_SECTOR_1 = 8'd43;
    localparam logic [7:0] HUE_SECTOR_2 = 8'd85;
    localparam logic [7:0] HUE_SECTOR_3 = 8'd128;
    localparam logic [7:0] HUE_SECTOR_4 = 8'd170;
    localparam logic [7:0] HUE_SECTOR_5 = 8'd213;
    localparam logic [7:0] HUE_TOP      = 8'd255;

    // Multiples of 510 removed from 6 * hue to form the position within a sector pair
    localparam logic [10:0] T_OFFSET_0 = 11'd0;
    localparam logic [10:0] T_OFFSET_1 = 11'd510;
    localparam logic [10:0] T_OFFSET_2 = 11'd1020;
    localparam logic [10:0] T_OFFSET_3 = 11'd1530;

    localparam logic [8:0] T_MIDPOINT = 9'd255;
    localparam logic [9:0] T_SPAN     = 10'd510;

    typedef enum logic [2:0] {
        SECTOR_0,
        SECTOR_1,
        SECTOR_2,
        SECTOR_3,
        SECTOR_4,
        SECTOR_5
    } sector_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  in_ready;
        logic                  out_valid;
    } hsvrgb_ctrl_t;

endpackage

/* rtl/hsvrgb_ctrl.sv */
// ----------------------------------------------------------------------------
// HSV to RGB pipeline control
// Valid bits of each stage and per-stage load enables with a ready chain.
// ----------------------------------------------------------------------------
module hsvrgb_ctrl
    import hsvrgb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         out_ready,
    output hsvrgb_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready;
    logic [NUM_STAGES-1:0] prev_valid;

    always_comb
    begin
        ready[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    assign prev_valid = {valid_reg[NUM_STAGES-2:0], in_valid};
    assign valid_next = (prev_valid & ready[NUM_STAGES-1:0])
                      | (valid_reg & ~ready[NUM_STAGES-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load      = ready[NUM_STAGES-1:0];
    assign ctrl.in_ready  = ready[0];
    assign ctrl.out_valid = valid_reg[NUM_STAGES-1];

endmodule

/* rtl/hsv_to_rgb_converter_core.sv */
// Throughput: one pixel per cycle while out_ready does not stall the output; six
// register stages, the longest holding one 24x26 reciprocal multiply.
// Reset: asynchronous, active low; clears the stage valid bits only.
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// 8-bit HSV plus alpha to 8-bit RGB plus alpha, exact integer arithmetic.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
    import hsvrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] value,
    input  logic [7:0] alpha_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] alpha_out
);

    hsvrgb_ctrl_t ctrl;

    hsvrgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    assign in_ready  = ctrl.in_ready;
    assign out_valid = ctrl.out_valid;

    // Stage 1: chroma, scaled value, sector and position
    logic [10:0] hue6;
    logic [10:0] t_offset;
    sector_t     sector_next;
    logic [10:0] t_full;

    logic [15:0] chroma_s1_reg;
    logic [15:0] v255_s1_reg;
    logic [8:0]  t_s1_reg;
    sector_t     sector_s1_reg;
    logic [7:0]  v_s1_reg;
    logic [7:0]  a_s1_reg;

    assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_comb
    begin
        priority if (hue >= HUE_TOP)
        begin
            sector_next = SECTOR_5;
            t_offset    = T_OFFSET_3;
        end
        else if (hue >= HUE_SECTOR_5)
        begin
            sector_next = SECTOR_5;
            t_offset    = T_OFFSET_2;
        end
        else if (hue >= HUE_SECTOR_4)
        begin
            sector_next = SECTOR_4;
            t_offset    = T_OFFSET_2;
        end
        else if (hue >= HUE_SECTOR_3)
        begin
            sector_next = SECTOR_3;
            t_offset    = T_OFFSET_1;
        end
        else if (hue >= HUE_SECTOR_2)
        begin
            sector_next = SECTOR_2;
            t_offset    = T_OFFSET_1;
        end
        else if (hue >= HUE_SECTOR_1)
        begin
            sector_next = SECTOR_1;
            t_offset    = T_OFFSET_0;
        end
        else
        begin
            sector_next = SECTOR_0;
            t_offset    = T_OFFSET_0;
        end
    end

    assign t_full = hue6 - t_offset;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            chroma_s1_reg <= {8'd0, saturation} * {8'd0, value};
            v255_s1_reg   <= {value, 8'd0} - {8'd0, value};
            t_s1_reg      <= t_full[8:0];
            sector_s1_reg <= sector_next;
            v_s1_reg      <= value;
            a_s1_reg      <= alpha_in;
        end
    end

    // Stage 2: achromatic part and distance weight
    logic [9:0]  t_mirror;
    logic [7:0]  weight_next;

    logic [15:0] chroma_s2_reg;
    logic [15:0] w_s2_reg;
    logic [7:0]  weight_s2_reg;
    sector_t     sector_s2_reg;
    logic [7:0]  v_s2_reg;
    logic [7:0]  a_s2_reg;

    assign t_mirror    = T_SPAN - {1'b0, t_s1_reg};
    assign weight_next = (t_s1_reg >= T_MIDPOINT) ? t_mirror[7:0] : t_s1_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            chroma_s2_reg <= chroma_s1_reg;
            w_s2_reg      <= v255_s1_reg - chroma_s1_reg;
            weight_s2_reg <= weight_next;
            sector_s2_reg <= sector_s1_reg;
            v_s2_reg      <= v_s1_reg;
            a_s2_reg      <= a_s1_reg;
        end
    end

    // Stage 3: products
    logic [23:0] p_s3_reg;
    logic [23:0] w255_s3_reg;
    logic [32:0] lo_prod_s3_reg;
    sector_t     sector_s3_reg;
    logic [7:0]  v_s3_reg;
    logic [7:0]  a_s3_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            p_s3_reg       <= {8'd0, chroma_s2_reg} * {16'd0, weight_s2_reg};
            w255_s3_reg    <= {w_s2_reg, 8'd0} - {8'd0, w_s2_reg};
            lo_prod_s3_reg <= {17'd0, w_s2_reg} * {16'd0, RECIP_255};
            sector_s3_reg  <= sector_s2_reg;
            v_s3_reg       <= v_s2_reg;
            a_s3_reg       <= a_s2_reg;
        end
    end

    // Stage 4: middle numerator and minimum channel
    logic [24:0] n_sum;

    logic [23:0] n_s4_reg;
    logic [7:0]  lo_s4_reg;
    sector_t     sector_s4_reg;
    logic [7:0]  v_s4_reg;
    logic [7:0]  a_s4_reg;

    assign n_sum = {1'b0, p_s3_reg} + {1'b0, w255_s3_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            n_s4_reg      <= n_sum[23:0];
            lo_s4_reg     <= lo_prod_s3_reg[RECIP_255_SHIFT+7:RECIP_255_SHIFT];
            sector_s4_reg <= sector_s3_reg;
            v_s4_reg      <= v_s3_reg;
            a_s4_reg      <= a_s3_reg;
        end
    end

    // Stage 5: middle channel
    logic [49:0] mid_prod;

    logic [7:0]  mid_s5_reg;
    logic [7:0]  lo_s5_reg;
    sector_t     sector_s5_reg;
    logic [7:0]  v_s5_reg;
    logic [7:0]  a_s5_reg;

    assign mid_prod = {26'd0, n_s4_reg} * {24'd0, RECIP_65025};

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            mid_s5_reg    <= mid_prod[RECIP_65025_SHIFT+7:RECIP_65025_SHIFT];
            lo_s5_reg     <= lo_s4_reg;
            sector_s5_reg <= sector_s4_reg;
            v_s5_reg      <= v_s4_reg;
            a_s5_reg      <= a_s4_reg;
        end
    end

    // Stage 6: channel routing into the output register
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;

    always_comb
    begin
        unique case (sector_s5_reg)
            SECTOR_0:
            begin
                red_next   = v_s5_reg;
                green_next = mid_s5_reg;
                blue_next  = lo_s5_reg;
            end
            SECTOR_1:
            begin
                red_next   = mid_s5_reg;
                green_next = v_s5_reg;
                blue_next  = lo_s5_reg;
            end
            SECTOR_2:
            begin
                red_next   = lo_s5_reg;
                green_next = v_s5_reg;
                blue_next  = mid_s5_reg;
            end
            SECTOR_3:
            begin
                red_next   = lo_s5_reg;
                green_next = mid_s5_reg;
                blue_next  = v_s5_reg;
            end
            SECTOR_4:
            begin
                red_next   = mid_s5_reg;
                green_next = lo_s5_reg;
                blue_next  = v_s5_reg;
            end
            default:
            begin
                red_next   = v_s5_reg;
                green_next = lo_s5_reg;
                blue_next  = mid_s5_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= a_s5_reg;
        end
    end

    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha_out = alpha_reg;

endmodule

/* rtl/hsvrgb_checker.sv */
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Port-level checks on the converter core, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] value,
    input logic [7:0] alpha_in,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha_out
);

    localparam int OCC_W = $clog2(NUM_STAGES + 2);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             in_fire;
    logic             out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_fire && !out_fire)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (out_fire && !in_fire)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Hold a waiting input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(hue) && $stable(saturation)
            && $stable(value) && $stable(alpha_in))
        else $error("waiting input transaction changed");

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(alpha_out))
        else $error("stalled output transaction changed");

    // Drop nothing: never more transactions in flight than stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(NUM_STAGES))
        else $error("more transactions in flight than pipeline stages");

    // Invent nothing: an output needs an earlier input
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("output transaction without a pending input");

    // Advance whenever the output stage can move
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled although the output stage can advance");

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_hsvrgb_checker (.*);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives pixels through the converter core under several idling mixes and a
// long output hold, predicts each RGB result with exact integer arithmetic
// and compares every output transaction field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import hsvrgb_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_PIXELS   = 30;
    localparam int RANDOM_PIXELS = 125;
    localparam int MAX_GAP       = 40;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_rgb_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
    logic [7:0] alpha_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;

    pixel_rgb_t rgb_expected[$];
    int         idle_pct;
    int         stall_pct;
    int         hold_seq;
    int         mismatch_count;
    int         pixels_sent;
    int         pixels_checked;

    hsv_to_rgb_converter_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .value      (value),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha_out  (alpha_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic pixel_rgb_t predict_rgb(input logic [7:0] h, input logic [7:0] s,
                                               input logic [7:0] v, input logic [7:0] a);
        int unsigned chroma;
        int unsigned v255;
        int unsigned six_h;
        int unsigned quotient;
        int unsigned t;
        int unsigned t_dist;
        int unsigned lo;
        int unsigned mid;
        sector_t     sector;
        pixel_rgb_t  px;
        chroma   = int'(s) * int'(v);
        v255     = 255 * int'(v);
        six_h    = 6 * int'(h);
        quotient = six_h / 255;
        if (quotient > SECTOR_5)
            quotient = SECTOR_5;
        sector   = sector_t'(quotient);
        t        = six_h % 510;
        t_dist   = (t >= 255) ? (t - 255) : (255 - t);
        lo       = (v255 - chroma) / 255;
        mid      = (chroma * (255 - t_dist) + 255 * (v255 - chroma)) / 65025;
        px.alpha = a;
        case (sector)
            SECTOR_0:
            begin
                px.red = v;          px.green = mid[7:0]; px.blue = lo[7:0];
            end
            SECTOR_1:
            begin
                px.red = mid[7:0];   px.green = v;        px.blue = lo[7:0];
            end
            SECTOR_2:
            begin
                px.red = lo[7:0];    px.green = v;        px.blue = mid[7:0];
            end
            SECTOR_3:
            begin
                px.red = lo[7:0];    px.green = mid[7:0]; px.blue = v;
            end
            SECTOR_4:
            begin
                px.red = mid[7:0];   px.green = lo[7:0];  px.blue = v;
            end
            default:
            begin
                px.red = v;          px.green = lo[7:0];  px.blue = mid[7:0];
            end
        endcase
        return px;
    endfunction

    task automatic send_pixel(input logic [7:0] h, input logic [7:0] s,
                              input logic [7:0] v, input logic [7:0] a);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        value      <= v;
        alpha_in   <= a;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        rgb_expected.push_back(predict_rgb(h, s, v, a));
        pixels_sent++;
    endtask

    function automatic logic [7:0] random_channel();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_pixel();
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] v;
        logic [7:0] a;
        h = random_channel();
        s = random_channel();
        v = random_channel();
        a = random_channel();
        send_pixel(h, s, v, a);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic test_channel_extremes();
        idle_pct  = 0;
        stall_pct = 0;
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd0,   8'd128);
        send_pixel(8'd128, 8'd0,   8'd255, 8'd170);
        send_pixel(8'd85,  8'd255, 8'd0,   8'd85);
        send_pixel(8'd255, 8'd128, 8'd200, 8'd1);
        send_pixel(8'd30,  8'd255, 8'd1,   8'd254);
    endtask

    task automatic test_sector_boundaries();
        logic [7:0] edges[11];
        edges = '{8'd42, 8'd43, 8'd84, 8'd85, 8'd127, 8'd128,
                  8'd169, 8'd170, 8'd212, 8'd213, 8'd254};
        foreach (edges[i])
            send_pixel(edges[i], 8'd255, 8'd255, ~edges[i]);
    endtask

    task automatic test_output_hold();
        idle_pct  = 0;
        stall_pct = 0;
        hold_seq++;
        repeat (HOLD_PIXELS) send_random_pixel();
    endtask

    task automatic test_random_stream(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (RANDOM_PIXELS) send_random_pixel();
    endtask

    initial
    begin : receiver
        int seen;
        int left;
        seen      = 0;
        left      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                left = HOLD_CYCLES;
            end
            if (left > 0)
            begin
                left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : result_checker
        pixel_rgb_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d %0d",
                             $time, red, green, blue, alpha_out);
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("alpha_out", want.alpha, alpha_out);
                    pixels_checked++;
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        hue            = 8'd0;
        saturation     = 8'd0;
        value          = 8'd0;
        alpha_in       = 8'd0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_seq       = 0;
        mismatch_count = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_channel_extremes();
        test_sector_boundaries();
        test_output_hold();
        test_random_stream(88, 0);
        test_random_stream(0, 88);
        test_random_stream(23, 23);
        test_random_stream(0, 0);

        in_valid <= 1'b0;
        while (rgb_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels, checked %0d: channel extremes, every sector edge,",
                 pixels_sent, pixels_checked);
        $display("a %0d-cycle output hold and random streams under four idling mixes",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
